@@ hw/rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg: shared definitions for the three-axis sample smoother
// Holds the sample width, the default history depth, the filter mode codes
// and the control bundle that the sequencer sends to every axis lane.
// ----------------------------------------------------------------------------
package tss_pkg;

	// Width of one axis sample and of one filtered result.
	localparam int unsigned SAMPLE_W = 16;

	// Default number of entries in each axis history ring.
	localparam int unsigned HISTORY_DEPTH_DEF = 16;

	// Filter mode codes.
	localparam logic MODE_AVG = 1'b0;
	localparam logic MODE_EXP = 1'b1;

	// Per-cycle commands from the sequencer to the axis lanes.
	typedef struct packed {
		logic wr_en;    // write the new sample into the ring
		logic exp_en;   // exponential update of the smoothed value
		logic acc_clr;  // clear the window accumulator and its stop flag
		logic rd_en;    // read one ring entry for the window sum
		logic mag_en;   // form the magnitude for the floor division
		logic mul_en;   // multiply by the reciprocal of the depth
		logic fin_en;   // load the window mean into the smoothed value
	} lane_ctrl_t;

endpackage

@@ hw/rtl/tss_lane.sv @@
// ----------------------------------------------------------------------------
// tss_lane: one axis of the smoother
// Keeps the axis history ring, sums it entry by entry up to the first zero
// entry, divides the sum by the depth with floor rounding, and keeps the
// smoothed value that also feeds the exponential update.
// ----------------------------------------------------------------------------
module tss_lane #(
	parameter int unsigned HISTORY_DEPTH = tss_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tss_pkg::lane_ctrl_t                   ctrl,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]      wr_addr,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]      rd_addr,
	input  logic signed [tss_pkg::SAMPLE_W-1:0]   sample,
	output logic signed [tss_pkg::SAMPLE_W-1:0]   smoothed
);

	localparam int unsigned SW       = tss_pkg::SAMPLE_W;
	localparam int unsigned IdxLog   = $clog2(HISTORY_DEPTH);
	localparam int unsigned SumW     = SW + IdxLog;
	// Reciprocal that gives an exact floor quotient for any magnitude below 2^SumW.
	localparam int unsigned RecipSh  = SumW + IdxLog;
	localparam int unsigned RecipW   = SumW + 1;
	localparam int unsigned ProdW    = SumW + RecipW;
	localparam int unsigned QuotW    = ProdW - RecipSh;
	localparam longint unsigned RecipL =
		((64'd1 << RecipSh) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
	localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
	localparam logic [SumW-1:0] DepthM1 = SumW'(HISTORY_DEPTH - 1);

	logic [SW-1:0]                ring_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0]     valid_q;
	logic [SW-1:0]                rd_data_s1;
	logic                         rd_vld_s1;
	logic                         ent_vld_s1;
	logic signed [SumW-1:0]       acc_q;
	logic                         stop_q;
	logic [SW-1:0]                entry;
	logic [SumW-1:0]              mag_s1;
	logic                         neg_s1;
	logic [ProdW-1:0]             prod_s2;
	logic                         neg_s2;
	logic [QuotW-1:0]             quot;
	logic [QuotW-1:0]             quot_signed;
	logic signed [SW+1:0]         old3;
	logic [SW-1:0]                exp_next;
	logic signed [SW-1:0]         smoothed_q;

	// Ring storage; written once per transaction, read once per sum cycle.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			ring_mem[wr_addr] <= sample;
		end
		if (ctrl.rd_en) begin
			rd_data_s1 <= ring_mem[rd_addr];
		end
	end

	// Valid bits make entries never written read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_vld_s1  <= 1'b0;
			ent_vld_s1 <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= ctrl.rd_en;
			if (ctrl.rd_en) begin
				ent_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign entry = ent_vld_s1 ? rd_data_s1 : '0;

	// Window accumulator; stops at the first zero entry until the next clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			stop_q <= 1'b0;
		end else if (ctrl.acc_clr) begin
			acc_q  <= '0;
			stop_q <= 1'b0;
		end else if (rd_vld_s1 && !stop_q) begin
			if (entry == '0) begin
				stop_q <= 1'b1;
			end else begin
				acc_q <= acc_q + SumW'($signed(entry));
			end
		end
	end

	// Floor division: a negative sum divides as -ceil(|sum| / depth).
	always_ff @(posedge clk) begin
		if (ctrl.mag_en) begin
			neg_s1 <= acc_q[SumW-1];
			mag_s1 <= acc_q[SumW-1] ? ((~acc_q) + 1'b1 + DepthM1) : acc_q;
		end
		if (ctrl.mul_en) begin
			neg_s2  <= neg_s1;
			prod_s2 <= ProdW'(mag_s1) * ProdW'(Recip);
		end
	end

	assign quot        = prod_s2[ProdW-1:RecipSh];
	assign quot_signed = neg_s2 ? ((~quot) + 1'b1) : quot;

	// Exponential update: floor(old * 3 / 4) + floor(sample / 4).
	assign old3     = (SW+2)'(smoothed_q) + ((SW+2)'(smoothed_q) <<< 1);
	assign exp_next = old3[SW+1:2] + {{2{sample[SW-1]}}, sample[SW-1:2]};

	// Smoothed value, shared by both modes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
		end else if (ctrl.exp_en) begin
			smoothed_q <= exp_next;
		end else if (ctrl.fin_en) begin
			smoothed_q <= quot_signed[SW-1:0];
		end
	end

	assign smoothed = smoothed_q;

endmodule

@@ hw/rtl/tss_ctrl.sv @@
// ----------------------------------------------------------------------------
// tss_ctrl: sequencer of the three-axis sample smoother
// Holds the filter mode and the shared write slot, and steps the lanes
// through the ring sweep and the division for each moving-average transaction.
// ----------------------------------------------------------------------------
module tss_ctrl #(
	parameter int unsigned HISTORY_DEPTH = tss_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              out_free,
	output logic                              out_load,
	output tss_pkg::lane_ctrl_t               ctrl,
	output logic [$clog2(HISTORY_DEPTH)-1:0]  wr_addr,
	output logic [$clog2(HISTORY_DEPTH)-1:0]  rd_addr
);

	localparam int unsigned IdxW = $clog2(HISTORY_DEPTH);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(HISTORY_DEPTH - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_MAG   = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]      state_q;
	logic [2:0]      state_d;
	logic            mode_q;
	logic [IdxW-1:0] slot_q;
	logic [IdxW-1:0] cnt_q;
	logic            accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_addr  = slot_q;
	assign rd_addr  = cnt_q;
	assign out_load = (state_q == ST_DONE) && out_free;

	// Lane commands decoded from the state, the accepted input and the mode.
	always_comb begin
		ctrl         = '0;
		ctrl.wr_en   = accept;
		ctrl.exp_en  = accept && (mode_q == tss_pkg::MODE_EXP);
		ctrl.acc_clr = accept && (mode_q == tss_pkg::MODE_AVG);
		ctrl.rd_en   = (state_q == ST_SUM);
		ctrl.mag_en  = (state_q == ST_MAG);
		ctrl.mul_en  = (state_q == ST_MUL);
		ctrl.fin_en  = (state_q == ST_FIN);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (mode_q == tss_pkg::MODE_EXP) ? ST_DONE : ST_SUM;
				end
			end
			ST_SUM: begin
				if (cnt_q == LastIdx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_MAG;
			ST_MAG:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_FIN;
			ST_FIN:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// State, mode, write slot and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= tss_pkg::MODE_AVG;
			slot_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				slot_q <= (slot_q == LastIdx) ? '0 : slot_q + 1'b1;
				cnt_q  <= '0;
			end else if (state_q == ST_SUM && cnt_q != LastIdx) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/three_axis_sample_smoother_top.sv @@
// ----------------------------------------------------------------------------
// three_axis_sample_smoother_top: three-axis moving average / exponential smoother
//
//   Channel   Signals                                   Handshake
//   -------   ---------------------------------------   ------------------
//   input     in_valid, in_ready, sample_x/y/z          valid / ready
//   output    out_valid, out_ready, mean_out_x/y/z      valid / ready
//   config    cfg_we, cfg_wdata (filter mode)           write enable only
//
// In moving-average mode the ring sweep reads one entry per cycle from each
// axis ring, then the floor division runs through its magnitude, multiply
// and final-load steps. Exponential mode skips the sweep and the division.
// Reset clears the rings (through valid bits), slot, mode and smoothed
// values at once. The output register holds a result while out_ready is
// low; the next input transaction is taken once that result has moved on
// into the output register.
// ----------------------------------------------------------------------------
module three_axis_sample_smoother_top #(
	parameter int unsigned HISTORY_DEPTH = tss_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tss_pkg::SAMPLE_W-1:0] sample_x,
	input  logic signed [tss_pkg::SAMPLE_W-1:0] sample_y,
	input  logic signed [tss_pkg::SAMPLE_W-1:0] sample_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tss_pkg::SAMPLE_W-1:0] mean_out_x,
	output logic signed [tss_pkg::SAMPLE_W-1:0] mean_out_y,
	output logic signed [tss_pkg::SAMPLE_W-1:0] mean_out_z,
	input  logic                                cfg_we,
	input  logic                                cfg_wdata
);

	localparam int unsigned IdxW = $clog2(HISTORY_DEPTH);

	tss_pkg::lane_ctrl_t                 ctrl;
	logic [IdxW-1:0]                     wr_addr;
	logic [IdxW-1:0]                     rd_addr;
	logic                                out_load;
	logic                                out_free;
	logic                                out_valid_q;
	logic signed [tss_pkg::SAMPLE_W-1:0] smooth_x;
	logic signed [tss_pkg::SAMPLE_W-1:0] smooth_y;
	logic signed [tss_pkg::SAMPLE_W-1:0] smooth_z;
	logic signed [tss_pkg::SAMPLE_W-1:0] out_x_q;
	logic signed [tss_pkg::SAMPLE_W-1:0] out_y_q;
	logic signed [tss_pkg::SAMPLE_W-1:0] out_z_q;

	assign out_free = !out_valid_q || out_ready;

	tss_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_free (out_free),
		.out_load (out_load),
		.ctrl     (ctrl),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	tss_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .wr_addr(wr_addr), .rd_addr(rd_addr),
		.sample(sample_x), .smoothed(smooth_x)
	);

	tss_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .wr_addr(wr_addr), .rd_addr(rd_addr),
		.sample(sample_y), .smoothed(smooth_y)
	);

	tss_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .wr_addr(wr_addr), .rd_addr(rd_addr),
		.sample(sample_z), .smoothed(smooth_z)
	);

	// Output register gathers the three lane results into one transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= smooth_x;
			out_y_q <= smooth_y;
			out_z_q <= smooth_z;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_out_x = out_x_q;
	assign mean_out_y = out_y_q;
	assign mean_out_z = out_z_q;

endmodule
